// ----- sv/gls_pkg.sv -----
// Shared constants and types for the gcd/lcm block.
package gls_pkg;

  localparam int OPERAND_WIDTH = 32;              // bits of each operand that are used
  localparam int IN_W          = 32;              // operand port width
  localparam int GCD_W         = 31;              // gcd port width
  localparam int LCM_W         = 62;              // lcm port width
  localparam int MAG_W         = OPERAND_WIDTH - 1;
  localparam int PROD_W        = 2 * MAG_W;
  localparam int SHIFT_W       = $clog2(MAG_W + 1);
  localparam int CNT_W         = $clog2(MAG_W);
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_GENERAL,
    KIND_ONE_ZERO,
    KIND_BOTH_ZERO
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [MAG_W-1:0] mag_a;
    logic [MAG_W-1:0] mag_b;
  } item_t;

endpackage

// ----- sv/gls_ifs.sv -----
// Valid/ready channel interfaces for operand and result words.
interface gls_in_if
  import gls_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] value_a;
  logic signed [IN_W-1:0] value_b;

  modport source(output valid, value_a, value_b, input ready);
  modport sink(input valid, value_a, value_b, output ready);
endinterface

interface gls_out_if
  import gls_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [GCD_W-1:0] gcd_out;
  logic [LCM_W-1:0] lcm_out;
  logic             status;

  modport source(output valid, gcd_out, lcm_out, status, input ready);
  modport sink(input valid, gcd_out, lcm_out, status, output ready);
endinterface

// ----- sv/gls_front.sv -----
// Front end: takes operand words, forms saturated magnitudes and classifies them.
module gls_front
  import gls_pkg::*;
(
  gls_in_if.sink in,
  output logic   push_valid,
  input  logic   push_ready,
  output item_t  push_item
);

  function automatic logic [MAG_W-1:0] magnitude(input logic [IN_W-1:0] raw);
    logic [OPERAND_WIDTH-1:0] v;
    logic [OPERAND_WIDTH-1:0] neg;
    v   = raw[OPERAND_WIDTH-1:0];
    neg = -v;
    if (!v[OPERAND_WIDTH-1]) begin
      return v[MAG_W-1:0];
    end else if (neg[OPERAND_WIDTH-1]) begin
      return '1;  // most negative pattern saturates
    end else begin
      return neg[MAG_W-1:0];
    end
  endfunction

  logic [MAG_W-1:0] mag_a;
  logic [MAG_W-1:0] mag_b;

  always_comb begin
    mag_a = magnitude(in.value_a);
    mag_b = magnitude(in.value_b);
    push_item.mag_a = mag_a;
    push_item.mag_b = mag_b;
    if (mag_a == '0 && mag_b == '0) begin
      push_item.kind = KIND_BOTH_ZERO;
    end else if (mag_a == '0 || mag_b == '0) begin
      push_item.kind = KIND_ONE_ZERO;
    end else begin
      push_item.kind = KIND_GENERAL;
    end
  end

  assign push_valid = in.valid;
  assign in.ready   = push_ready;

endmodule

// ----- sv/gls_queue.sv -----
// Two-entry queue between the front end and the compute engine.
module gls_queue
  import gls_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != QCNT_W'(QDEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count exceeds depth");
`endif

endmodule

// ----- sv/gls_back.sv -----
// Compute engine: binary gcd, restoring divide by the gcd, then one multiply for the lcm.
module gls_back
  import gls_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    pop_valid,
  output logic    pop_ready,
  input  item_t   pop_item,
  gls_out_if.source out
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIV,
    S_MUL,
    S_DONE
  } state_t;

  state_t             state;
  logic [MAG_W-1:0]   u;
  logic [MAG_W-1:0]   v;
  logic [SHIFT_W-1:0] k;
  logic [MAG_W-1:0]   g;
  logic [MAG_W-1:0]   dvd;      // dividend in, quotient out
  logic [MAG_W-1:0]   rem;
  logic [MAG_W-1:0]   b_keep;
  logic [CNT_W-1:0]   cnt;
  logic [PROD_W-1:0]  lcm;
  logic               st;

  logic [MAG_W:0]     trial;
  logic [MAG_W:0]     diff;
  logic               take;
  logic [MAG_W-1:0]   u_next;
  logic [MAG_W-1:0]   v_next;
  logic [SHIFT_W-1:0] k_next;

  // one restoring divide step
  always_comb begin
    trial = {rem, dvd[MAG_W-1]};
    diff  = trial - {1'b0, g};
    take  = !diff[MAG_W];
  end

  // one binary gcd step
  always_comb begin
    u_next = u;
    v_next = v;
    k_next = k;
    if (!u[0] && !v[0]) begin
      u_next = u >> 1;
      v_next = v >> 1;
      k_next = k + 1'b1;
    end else if (!u[0]) begin
      u_next = u >> 1;
    end else if (!v[0]) begin
      v_next = v >> 1;
    end else if (u >= v) begin
      u_next = (u - v) >> 1;
    end else begin
      v_next = (v - u) >> 1;
    end
  end

  assign pop_ready   = (state == S_IDLE);
  assign out.valid   = (state == S_DONE);
  assign out.gcd_out = GCD_W'(g);
  assign out.lcm_out = LCM_W'(lcm);
  assign out.status  = st;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            u      <= pop_item.mag_a;
            v      <= pop_item.mag_b;
            dvd    <= pop_item.mag_a;
            b_keep <= pop_item.mag_b;
            k      <= '0;
            g      <= pop_item.mag_a | pop_item.mag_b;
            lcm    <= '0;
            st     <= (pop_item.kind == KIND_BOTH_ZERO);
            state  <= (pop_item.kind == KIND_GENERAL) ? S_GCD : S_DONE;
          end
        end
        S_GCD: begin
          if (u == '0 || v == '0) begin
            g     <= (u | v) << k;
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            u <= u_next;
            v <= v_next;
            k <= k_next;
          end
        end
        S_DIV: begin
          rem <= take ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
          dvd <= {dvd[MAG_W-2:0], take};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(MAG_W - 1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          lcm   <= PROD_W'(dvd) * PROD_W'(b_keep);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_zero_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && st) |-> (g == '0 && lcm == '0))
    else $error("both-zero word carries nonzero result");

  a_div_flow: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> (state == S_DIV || state == S_MUL))
    else $error("divide phase left early");

  a_mul_flow: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> (state == S_DONE))
    else $error("multiply did not complete in one cycle");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !out.ready) |=> (state == S_DONE && $stable(lcm) && $stable(g)))
    else $error("result changed while stalled");
`endif

endmodule

// ----- sv/gcd_lcm_subtractive_top.sv -----
// Top level of the gcd/lcm block: front end, queue and compute engine.
//
// Usage:
//   in  : operand words (value_a, value_b), valid/ready. Only the low
//         OPERAND_WIDTH bits of each are used; magnitudes are taken, the
//         most negative pattern saturating to the largest positive value.
//   out : result words (gcd_out, lcm_out, status), valid/ready, one per
//         operand word, in order. status is 1 when both operands are zero.
// Operation: a word with a zero operand goes from the queue straight to the
//   result state. Otherwise the engine runs the binary gcd loop until u or v
//   is zero, then the restoring divide by the gcd, then the multiply for the
//   lcm; only the gcd loop varies in length with the operands.
// Flow: one word in flight in the engine; a two-entry queue in front keeps
//   accepting words while the engine works or its result waits.
// Reset (rst, synchronous) empties the queue and idles the engine.
// A stalled receiver holds the result steady; the engine takes no new word
//   until its result is taken, and in.ready drops once the queue is full.
module gcd_lcm_subtractive_top
  import gls_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  gls_in_if.sink     in,
  gls_out_if.source  out
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  gls_front u_front (
    .in         (in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  gls_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_item  (pop_item)
  );

  gls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out       (out)
  );

endmodule
